### src/rfc_pkg.sv
// Shared constants, result record type and CRC step for the record frame checker.
// Used by rfc_front, rfc_queue and record_frame_checker; depends on nothing.
`default_nettype none

package rfc_pkg;

    // Record geometry
    localparam int ID_BYTES   = 24;
    localparam int COUNT_BITS = 32;
    localparam int PREFIX_LEN = 16;
    localparam int HDR_V1     = ID_BYTES + 26;
    localparam int HDR_V2     = ID_BYTES + 24;
    localparam int HBASE      = PREFIX_LEN + ID_BYTES;
    localparam int MIN_LEN    = PREFIX_LEN + HDR_V2 + 4;
    localparam int POS_W      = 34;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

    localparam logic [7:0] MAGIC [4] = '{8'h4A, 8'h44, 8'h42, 8'h32};

    // Result kinds
    localparam logic [1:0] KIND_ID      = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_STATUS  = 2'd2;

    // Status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_SHORT   = 3'd1;
    localparam logic [2:0] ST_MAGIC   = 3'd2;
    localparam logic [2:0] ST_VERSION = 3'd3;
    localparam logic [2:0] ST_SIZE    = 3'd4;
    localparam logic [2:0] ST_CRC     = 3'd5;

    // Result queue depth
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    typedef struct packed {
        logic [1:0]  kind;
        logic        end_of_run;
        logic [31:0] computed_crc;
        logic [31:0] revision;
        logic [63:0] updated_ms;
        logic [63:0] created_ms;
        logic [15:0] flags;
        logic [2:0]  status;
        logic [7:0]  out_byte;
    } res_t;

    // Push request from the front end: up to two results per byte
    typedef struct packed {
        logic push_a;
        logic push_b;
    } push_t;

    // Reflected CRC-32 over one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### src/rfc_front.sv
// Front end: tracks byte position, captures header fields, runs the payload CRC
// and classifies each byte into zero, one or two results. Uses rfc_pkg.
`default_nettype none

module rfc_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           take,
    input  wire logic [7:0]     in_byte,
    input  wire logic           in_last,
    output rfc_pkg::push_t      push,
    output rfc_pkg::res_t       res_a,
    output rfc_pkg::res_t       res_b
);

    logic [rfc_pkg::COUNT_BITS-1:0] byte_count_reg, byte_count_next;
    logic [31:0] crc_reg, crc_next;
    logic        magic_good_reg, magic_good_next;
    logic [15:0] version_reg, version_next;
    logic [15:0] flags_reg, flags_next;
    logic [31:0] hdr_len_reg, hdr_len_next;
    logic [31:0] pay_len_reg, pay_len_next;
    logic [63:0] created_reg, created_next;
    logic [63:0] updated_reg, updated_next;
    logic [31:0] revision_reg, revision_next;
    logic [31:0] hcrc_reg, hcrc_next;
    logic [31:0] tcrc_reg, tcrc_next;

    logic [rfc_pkg::POS_W-1:0] pos, ps, pe, hoff, toff, seen, expect_len;
    logic        vok;
    logic        byte_out;
    logic [1:0]  byte_kind;
    logic [31:0] cc;
    logic [2:0]  st;
    rfc_pkg::res_t byte_res, stat_res;

    assign pos  = rfc_pkg::POS_W'(byte_count_reg);
    assign ps   = rfc_pkg::POS_W'(rfc_pkg::PREFIX_LEN) + rfc_pkg::POS_W'(hdr_len_reg);
    assign pe   = ps + rfc_pkg::POS_W'(pay_len_reg);
    assign hoff = pos - rfc_pkg::POS_W'(rfc_pkg::HBASE);
    assign toff = pos - pe;
    assign vok  = (version_reg == 16'd1 && hdr_len_reg == 32'(rfc_pkg::HDR_V1)) ||
                  (version_reg == 16'd2 && hdr_len_reg == 32'(rfc_pkg::HDR_V2));

    // Classify the byte and update captured fields
    always_comb
    begin
        magic_good_next = magic_good_reg;
        version_next    = version_reg;
        flags_next      = flags_reg;
        hdr_len_next    = hdr_len_reg;
        pay_len_next    = pay_len_reg;
        created_next    = created_reg;
        updated_next    = updated_reg;
        revision_next   = revision_reg;
        hcrc_next       = hcrc_reg;
        tcrc_next       = tcrc_reg;
        crc_next        = crc_reg;
        byte_out        = 1'b0;
        byte_kind       = rfc_pkg::KIND_ID;

        if (pos < rfc_pkg::POS_W'(4))
        begin
            if (in_byte != rfc_pkg::MAGIC[pos[1:0]])
                magic_good_next = 1'b0;
        end
        else if (pos < rfc_pkg::POS_W'(6))
            version_next[8*pos[0] +: 8] = in_byte;
        else if (pos < rfc_pkg::POS_W'(8))
            flags_next[8*pos[0] +: 8] = in_byte;
        else if (pos < rfc_pkg::POS_W'(12))
            hdr_len_next[8*pos[1:0] +: 8] = in_byte;
        else if (pos < rfc_pkg::POS_W'(16))
            pay_len_next[8*pos[1:0] +: 8] = in_byte;
        else if (pos < rfc_pkg::POS_W'(rfc_pkg::HBASE))
            byte_out = 1'b1;
        else if (pos < rfc_pkg::POS_W'(rfc_pkg::HBASE + 8))
            created_next[8*hoff[2:0] +: 8] = in_byte;
        else if (pos < rfc_pkg::POS_W'(rfc_pkg::HBASE + 16))
            updated_next[8*hoff[2:0] +: 8] = in_byte;
        else if (pos < rfc_pkg::POS_W'(rfc_pkg::HBASE + 20))
            revision_next[8*hoff[1:0] +: 8] = in_byte;
        else if (pos < rfc_pkg::POS_W'(rfc_pkg::HBASE + 24))
            hcrc_next[8*hoff[1:0] +: 8] = in_byte;
        else if (vok && pos >= ps && pos < pe)
        begin
            crc_next  = rfc_pkg::crc_byte(crc_reg, in_byte);
            byte_out  = 1'b1;
            byte_kind = rfc_pkg::KIND_PAYLOAD;
        end
        else if (vok && pos >= pe && pos < pe + rfc_pkg::POS_W'(4))
            tcrc_next[8*toff[1:0] +: 8] = in_byte;

        byte_count_next = (byte_count_reg < rfc_pkg::COUNT_MAX) ?
                          byte_count_reg + 1'b1 : byte_count_reg;
    end

    // Final status in check order
    assign seen       = rfc_pkg::POS_W'(byte_count_next);
    assign expect_len = rfc_pkg::POS_W'(rfc_pkg::PREFIX_LEN) + rfc_pkg::POS_W'(hdr_len_next) +
                        rfc_pkg::POS_W'(pay_len_next) + rfc_pkg::POS_W'(4);
    assign cc = ~crc_next;

    always_comb
    begin
        if (seen < rfc_pkg::POS_W'(rfc_pkg::MIN_LEN))
            st = rfc_pkg::ST_SHORT;
        else if (!magic_good_next)
            st = rfc_pkg::ST_MAGIC;
        else if (!vok)
            st = rfc_pkg::ST_VERSION;
        else if (seen != expect_len)
            st = rfc_pkg::ST_SIZE;
        else if (cc != hcrc_next || cc != tcrc_next)
            st = rfc_pkg::ST_CRC;
        else
            st = rfc_pkg::ST_OK;
    end

    // Build results; the passed byte goes first when both are present
    always_comb
    begin
        byte_res          = '0;
        byte_res.kind     = byte_kind;
        byte_res.out_byte = in_byte;

        stat_res              = '0;
        stat_res.kind         = rfc_pkg::KIND_STATUS;
        stat_res.status       = st;
        stat_res.flags        = flags_next;
        stat_res.created_ms   = created_next;
        stat_res.updated_ms   = updated_next;
        stat_res.revision     = revision_next;
        stat_res.computed_crc = cc;
        stat_res.end_of_run   = 1'b1;

        res_a       = byte_out ? byte_res : stat_res;
        res_b       = stat_res;
        push.push_a = take && (byte_out || in_last);
        push.push_b = take && byte_out && in_last;
    end

    // Control state: clear on reset and at the end of each record
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            crc_reg        <= rfc_pkg::CRC_INIT;
            magic_good_reg <= 1'b1;
            version_reg    <= '0;
            flags_reg      <= '0;
            hdr_len_reg    <= '0;
            pay_len_reg    <= '0;
            created_reg    <= '0;
            updated_reg    <= '0;
            revision_reg   <= '0;
            hcrc_reg       <= '0;
            tcrc_reg       <= '0;
        end
        else if (take)
        begin
            if (in_last)
            begin
                byte_count_reg <= '0;
                crc_reg        <= rfc_pkg::CRC_INIT;
                magic_good_reg <= 1'b1;
                version_reg    <= '0;
                flags_reg      <= '0;
                hdr_len_reg    <= '0;
                pay_len_reg    <= '0;
                created_reg    <= '0;
                updated_reg    <= '0;
                revision_reg   <= '0;
                hcrc_reg       <= '0;
                tcrc_reg       <= '0;
            end
            else
            begin
                byte_count_reg <= byte_count_next;
                crc_reg        <= crc_next;
                magic_good_reg <= magic_good_next;
                version_reg    <= version_next;
                flags_reg      <= flags_next;
                hdr_len_reg    <= hdr_len_next;
                pay_len_reg    <= pay_len_next;
                created_reg    <= created_next;
                updated_reg    <= updated_next;
                revision_reg   <= revision_next;
                hcrc_reg       <= hcrc_next;
                tcrc_reg       <= tcrc_next;
            end
        end
    end

endmodule

`default_nettype wire

### src/rfc_queue.sv
// Result queue between front end and output port: two writes, one read per cycle.
// The head entry drives the output directly. Uses rfc_pkg.
`default_nettype none

module rfc_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire rfc_pkg::push_t push,
    input  wire rfc_pkg::res_t wr_a,
    input  wire rfc_pkg::res_t wr_b,
    output logic               room,
    output logic               head_valid,
    output rfc_pkg::res_t      head,
    input  wire logic          pop
);

    rfc_pkg::res_t mem_reg [rfc_pkg::QDEPTH];
    logic [rfc_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg;
    logic [rfc_pkg::QPTR_W:0]   count_reg, count_next;
    logic [rfc_pkg::QPTR_W-1:0] wr_ptr_b;
    logic do_pop;

    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign room       = (count_reg <= (rfc_pkg::QPTR_W+1)'(rfc_pkg::QDEPTH - 2));
    assign do_pop     = pop && head_valid;
    assign wr_ptr_b   = wr_ptr_reg + 1'b1;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + rfc_pkg::QPTR_W'(push.push_a) + rfc_pkg::QPTR_W'(push.push_b);
        count_next  = count_reg + (rfc_pkg::QPTR_W+1)'(push.push_a)
                    + (rfc_pkg::QPTR_W+1)'(push.push_b) - (rfc_pkg::QPTR_W+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push.push_a)
            mem_reg[wr_ptr_reg] <= wr_a;
        if (push.push_b)
            mem_reg[wr_ptr_b] <= wr_b;
    end

endmodule

`default_nettype wire

### src/record_frame_checker.sv
// Channel  | dir | tdata / tuser / tlast
// s_axis   | in  | tdata: in_byte[7:0]; tlast: in_last
// m_axis   | out | tdata: out_byte,status,flags,created_ms,updated_ms,revision,
//          |     |        computed_crc (low to high, 5 zero pad bits); tuser: kind;
//          |     |        tlast: end_of_run
// One byte is taken per cycle unless the queue stalls the input; the per-byte CRC step
// and field capture are combinational. A byte yields zero, one or two results; a final
// id/payload byte yields two. A four-entry result queue decouples the two sides;
// input stalls only when fewer than two entries are free.
// rst_n clears position, CRC and captured fields; the state also clears after each status.
// Top level of the record frame checker; instantiates rfc_front and rfc_queue, uses rfc_pkg.
`default_nettype none

module record_frame_checker (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // in_byte[7:0]
    input  wire logic         s_tlast,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [223:0]      m_tdata,   // out_byte, status, flags, created_ms,
                                         // updated_ms, revision, computed_crc
    output logic [1:0]        m_tuser,   // kind
    output logic              m_tlast
);

    rfc_pkg::push_t push;
    rfc_pkg::res_t  res_a, res_b, head;
    logic room, take;

    assign s_tready = room;
    assign take     = s_tvalid && room;

    rfc_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .in_byte (s_tdata),
        .in_last (s_tlast),
        .push    (push),
        .res_a   (res_a),
        .res_b   (res_b)
    );

    rfc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .wr_a       (res_a),
        .wr_b       (res_b),
        .room       (room),
        .head_valid (m_tvalid),
        .head       (head),
        .pop        (m_tready)
    );

    // Pack the head result onto the output bus
    assign m_tdata = {5'd0, head.computed_crc, head.revision, head.updated_ms,
                      head.created_ms, head.flags, head.status, head.out_byte};
    assign m_tuser = head.kind;
    assign m_tlast = head.end_of_run;

endmodule

`default_nettype wire
